/* rtl/core/sdq_pkg.sv */
package sdq_pkg;

	// Default number of entries held by the deque.
	localparam int CAPACITY_DEF = 16;

	// Command codes carried on the command field.
	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_e_t;

	// Result status codes.
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_t;

endpackage

/* rtl/core/sdq_ctrl.sv */
module sdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output sdq_pkg::ctrl_t ctrl
);
	import sdq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready    = 1'b0;
		ctrl.load   = 1'b0;
		ctrl.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			S_EXEC: begin
				ctrl.commit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/sdq_datapath.sv */
module sdq_datapath #(
	parameter int CAPACITY = sdq_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sdq_pkg::ctrl_t     ctrl,
	input  logic [1:0]         command,
	input  logic signed [31:0] push_value,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [4:0]         entry_count,
	output logic               is_empty,
	output logic               is_full
);
	import sdq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	cmd_e_t      cmd_q;
	logic [31:0] val_q;
	logic [31:0] slots_q [CAPACITY];
	logic [CW-1:0] count_q;

	logic [31:0]   slots_d [CAPACITY];
	logic [CW-1:0] count_d;
	logic [1:0]    stat_d;
	logic [31:0]   pop_d;
	logic          full;
	logic          empty;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] back_idx;

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign last_idx = IW'(count_q - CW'(1));
	assign back_idx = IW'(count_d - CW'(1));

	always_comb begin
		slots_d = slots_q;
		count_d = count_q;
		stat_d  = STAT_DONE;
		pop_d   = '0;
		unique case (cmd_q)
			CMD_PUSH_FRONT: begin
				if (full) begin
					stat_d = STAT_FULL;
				end else begin
					slots_d[0] = val_q;
					for (int i = 1; i < CAPACITY; i++) slots_d[i] = slots_q[i-1];
					count_d = count_q + CW'(1);
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					stat_d = STAT_FULL;
				end else begin
					slots_d[count_q[IW-1:0]] = val_q;
					count_d = count_q + CW'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					pop_d = slots_q[0];
					for (int i = 0; i < CAPACITY - 1; i++) slots_d[i] = slots_q[i+1];
					slots_d[CAPACITY-1] = '0;
					count_d = count_q - CW'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					pop_d   = slots_q[last_idx];
					count_d = count_q - CW'(1);
				end
			end
		endcase
	end

	// Command capture and entry storage carry no reset.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd_e_t'(command);
			val_q <= push_value;
		end
		if (ctrl.commit) begin
			slots_q      <= slots_d;
			status       <= stat_d;
			popped_value <= pop_d;
			front_value  <= (count_d != '0) ? slots_d[0] : '0;
			back_value   <= (count_d != '0) ? slots_d[back_idx] : '0;
			entry_count  <= 5'(count_d);
			is_empty     <= (count_d == '0);
			is_full      <= (count_d == CW'(CAPACITY));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.commit) begin
			count_q <= count_d;
		end
	end

endmodule

/* rtl/core/shift_register_deque.sv */
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | command, push_value
// output  | out_valid / out_ready| status, popped_value, front_value, back_value,
//         |                      | entry_count, is_empty, is_full
//
// Each item is captured while idle; the execute state shifts the entry array and
// loads the result register. The next item is taken in the cycle after that.
// The execute step waits while a previous result still sits unaccepted in the
// result register, and no further item is taken until that step has run.
// Reset (arst_n low) empties the deque at once; entry contents are not cleared.

module shift_register_deque #(
	parameter int CAPACITY = sdq_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [4:0]         entry_count,
	output logic               is_empty,
	output logic               is_full
);
	import sdq_pkg::*;

	// Load and commit strobes from the controller to the datapath.
	ctrl_t ctrl;

	// The controller sequences capture and execute and owns the result valid flag.
	sdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	// The datapath holds the ordered entry array, with slot zero at the front,
	// and shifts all entries in parallel on a front push or front pop.
	sdq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.command      (command),
		.push_value   (push_value),
		.status       (status),
		.popped_value (popped_value),
		.front_value  (front_value),
		.back_value   (back_value),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

endmodule

/* rtl/core/sdq_checker.sv */
module sdq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic signed [31:0] popped_value,
	input logic signed [31:0] front_value,
	input logic signed [31:0] back_value,
	input logic [4:0]         entry_count,
	input logic               is_empty,
	input logic               is_full
);
	import sdq_pkg::*;

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// One item at a time: no item is taken in the cycle after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accept");

	// An empty deque reports zero count and zero front and back values.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> entry_count == 5'd0 && front_value == 32'sd0
			&& back_value == 32'sd0)
		else $error("empty result with nonzero fields");

	// A rejected command pops nothing.
	a_reject_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_DONE |-> popped_value == 32'sd0)
		else $error("rejected command reports a popped value");

	// Full and empty never show together.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_full |-> !is_empty)
		else $error("result is both full and empty");

endmodule

bind shift_register_deque sdq_checker u_sdq_checker (.*);
